@@ hw/rtl/content_length_deframer_assert.svh @@
// Assertion macros used by the deframer RTL (included by clen_core).
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef CONTENT_LENGTH_DEFRAMER_ASSERT_SVH
`define CONTENT_LENGTH_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CLD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/clen_pkg.sv @@
// Shared types, constants and helpers for the content-length deframer.
// No dependencies; imported by every deframer module.
`default_nettype none

package clen_pkg;

    localparam int LEN_W      = 32;   // width of the parsed length and counters
    localparam int MSG_W      = 32;   // width of the message_length result field
    localparam int PREFIX_LEN = 15;   // length of "Content-Length:"

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [2:0] {
        KIND_BODY    = 3'd0,
        KIND_EMPTY   = 3'd1,
        KIND_HDR_END = 3'd2,
        KIND_NO_LEN  = 3'd3,
        KIND_TRUNC   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_byte;
        logic             last;
        logic [MSG_W-1:0] message_length;
    } result_t;

    // Character of the header tag at a given position.
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/clen_in_reg.sv @@
// Input register stage of the deframer: captures one request per cycle while load is asserted.
// Depends on clen_pkg.
`default_nettype none

module clen_in_reg
    import clen_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,      // a request is accepted this cycle
    input  wire item_t item_in,
    input  wire logic  advance,   // the held item is consumed this cycle
    output logic       valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload unless a new request lands.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/clen_core.sv @@
// Header parser and body counter of the deframer: state registers plus
// the per-byte next-state and result logic. Depends on clen_pkg and the
// assertion header.
`default_nettype none
`include "content_length_deframer_assert.svh"

module clen_core
    import clen_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,       // process the presented item this cycle
    input  wire item_t item,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        LS_MATCH  = 3'd0,
        LS_SKIP   = 3'd1,
        LS_SIGN   = 3'd2,
        LS_DIGITS = 3'd3,
        LS_DONE   = 3'd4,
        LS_IGNORE = 3'd5
    } line_state_t;

    phase_t      phase_reg,    phase_next;
    line_state_t ls_reg,       ls_next;
    logic [3:0]  pos_reg,      pos_next;
    logic        nonempty_reg, nonempty_next;
    len_t        acc_reg,      acc_next;
    logic        vneg_reg,     vneg_next;
    logic        known_reg,    known_next;
    len_t        len_reg,      len_next;
    logic        lneg_reg,     lneg_next;
    len_t        rem_reg,      rem_next;

    logic [7:0]       c;
    logic             is_ws;
    logic             is_sign;
    logic             is_digit;
    logic [LEN_W+3:0] acc_wide;
    len_t             acc_digit;
    len_t             rem_dec;
    logic [3:0]       pos_inc;
    logic             clear_all;

    assign c        = item.in_byte;
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign pos_inc  = pos_reg + 4'd1;
    assign rem_dec  = (rem_reg == '0) ? '0 : rem_reg - len_t'(1);

    // acc*10 + digit, saturating at the largest length value
    always_comb
    begin
        acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + (LEN_W+4)'(c - CH_ZERO);
        if (acc_wide > {4'b0, LEN_MAX})
        begin
            acc_digit = LEN_MAX;
        end
        else
        begin
            acc_digit = acc_wide[LEN_W-1:0];
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        ls_next       = ls_reg;
        pos_next      = pos_reg;
        nonempty_next = nonempty_reg;
        acc_next      = acc_reg;
        vneg_next     = vneg_reg;
        known_next    = known_reg;
        len_next      = len_reg;
        lneg_next     = lneg_reg;
        rem_next      = rem_reg;
        clear_all     = 1'b0;
        res_valid     = 1'b0;
        res           = '0;
        res.kind      = KIND_BODY;

        if (step)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (item.end_of_input)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_HDR_END;
                    res.last  = 1'b1;
                    clear_all = 1'b1;
                end
                else if (c == CH_CR)
                begin
                    // drop carriage returns
                end
                else if (c == CH_LF)
                begin
                    if (!nonempty_reg)
                    begin
                        // blank line ends the headers
                        if (!known_reg || lneg_reg)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_NO_LEN;
                            res.last  = 1'b1;
                            clear_all = 1'b1;
                        end
                        else if (len_reg == '0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_EMPTY;
                            res.last  = 1'b1;
                            clear_all = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            rem_next   = len_reg;
                        end
                    end
                    else if ((ls_reg == LS_SKIP) || (ls_reg == LS_SIGN) ||
                             (ls_reg == LS_DIGITS) || (ls_reg == LS_DONE))
                    begin
                        known_next = 1'b1;
                        len_next   = acc_reg;
                        lneg_next  = vneg_reg && (acc_reg != '0);
                    end
                    ls_next       = LS_MATCH;
                    pos_next      = '0;
                    nonempty_next = 1'b0;
                    acc_next      = '0;
                    vneg_next     = 1'b0;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    unique case (ls_reg)
                        LS_MATCH:
                        begin
                            if ((pos_reg < 4'(PREFIX_LEN)) && (c == prefix_char(pos_reg)))
                            begin
                                pos_next = pos_inc;
                                if (pos_inc == 4'(PREFIX_LEN))
                                begin
                                    ls_next = LS_SKIP;
                                end
                            end
                            else
                            begin
                                ls_next = LS_IGNORE;
                            end
                        end
                        LS_SKIP:
                        begin
                            if (is_ws)
                            begin
                                // skip leading whitespace
                            end
                            else if (is_sign)
                            begin
                                vneg_next = (c == CH_MINUS);
                                ls_next   = LS_SIGN;
                            end
                            else if (is_digit)
                            begin
                                acc_next = acc_digit;
                                ls_next  = LS_DIGITS;
                            end
                            else
                            begin
                                ls_next = LS_DONE;
                            end
                        end
                        LS_SIGN, LS_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_digit;
                                ls_next  = LS_DIGITS;
                            end
                            else
                            begin
                                ls_next = LS_DONE;
                            end
                        end
                        default:
                        begin
                            // ignore the rest of the line
                        end
                    endcase
                end
            end
            else
            begin
                res_valid          = 1'b1;
                res.message_length = MSG_W'(len_reg);
                if (item.end_of_input)
                begin
                    res.kind  = KIND_TRUNC;
                    res.last  = 1'b1;
                    clear_all = 1'b1;
                end
                else
                begin
                    res.kind     = KIND_BODY;
                    res.out_byte = c;
                    rem_next     = rem_dec;
                    if (rem_dec == '0)
                    begin
                        res.last  = 1'b1;
                        clear_all = 1'b1;
                    end
                end
            end
        end

        // restart after any closing result
        if (clear_all)
        begin
            phase_next    = PH_HEADER;
            ls_next       = LS_MATCH;
            pos_next      = '0;
            nonempty_next = 1'b0;
            acc_next      = '0;
            vneg_next     = 1'b0;
            known_next    = 1'b0;
            len_next      = '0;
            lneg_next     = 1'b0;
            rem_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            ls_reg       <= LS_MATCH;
            pos_reg      <= '0;
            nonempty_reg <= 1'b0;
            acc_reg      <= '0;
            vneg_reg     <= 1'b0;
            known_reg    <= 1'b0;
            len_reg      <= '0;
            lneg_reg     <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ls_reg       <= ls_next;
            pos_reg      <= pos_next;
            nonempty_reg <= nonempty_next;
            acc_reg      <= acc_next;
            vneg_reg     <= vneg_next;
            known_reg    <= known_next;
            len_reg      <= len_next;
            lneg_reg     <= lneg_next;
            rem_reg      <= rem_next;
        end
    end

    `CLD_ASSERT_IMP(a_error_is_last, res_valid && (res.kind != KIND_BODY), res.last,
        "non-body result without last")
    `CLD_ASSERT_IMP(a_body_has_count, phase_reg == PH_BODY, rem_reg != '0,
        "body phase with no bytes remaining")
    `CLD_ASSERT_NEXT(a_last_restarts, res_valid && res.last,
        (phase_reg == PH_HEADER) && !known_reg && (ls_reg == LS_MATCH) && (rem_reg == '0),
        "state not cleared after closing result")
    `CLD_ASSERT_IMP(a_header_err_zero,
        res_valid && ((res.kind == KIND_HDR_END) || (res.kind == KIND_NO_LEN)),
        (res.out_byte == 8'h00) && (res.message_length == '0),
        "header error result carries data")

endmodule

`default_nettype wire

@@ hw/rtl/clen_out_reg.sv @@
// Result register of the deframer: holds one result until the sink takes it.
// Depends on clen_pkg.
`default_nettype none

module clen_out_reg
    import clen_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,      // a new result is produced this cycle
    input  wire result_t res_in,
    input  wire logic    ready,     // sink takes the held result
    output logic         free,      // register can take a result this cycle
    output logic         valid,
    output result_t      res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/content_length_deframer.sv @@
// Content-length deframer: an accepted request passes through the input
// register, then the parser, to its result in the result register on the master side.
// One byte per cycle unless the sink stalls; the parser touches each byte once.
// Backpressure on the master side stalls the input register, then s_axis_tready.
// rst_n (asynchronous, active low) empties both registers and returns the
// parser to the header phase with no length known.
`default_nettype none

module content_length_deframer
    import clen_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tuser,   // [0] end_of_input

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] out_byte, [39:8] message_length
    output logic             m_axis_tlast,   // last
    output logic [2:0]       m_axis_tuser    // [2:0] kind
);

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_free;
    logic    advance;
    logic    core_valid;
    result_t core_res;
    logic    out_valid;
    result_t out_res;

    assign in_item.in_byte      = s_axis_tdata;
    assign in_item.end_of_input = s_axis_tuser;

    // Advance the held byte whenever the result register has room; accept
    // a new request whenever the input register is empty or being drained.
    assign advance       = held_valid && out_free;
    assign s_axis_tready = !held_valid || advance;

    clen_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s_axis_tvalid && s_axis_tready),
        .item_in (in_item),
        .advance (advance),
        .valid   (held_valid),
        .item    (held_item)
    );

    // Parse the header or count the body, one byte per step.
    clen_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (held_item),
        .res_valid (core_valid),
        .res       (core_res)
    );

    // Hold the result for the sink.
    clen_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (core_valid),
        .res_in (core_res),
        .ready  (m_axis_tready),
        .free   (out_free),
        .valid  (out_valid),
        .res    (out_res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_res.message_length, out_res.out_byte};
    assign m_axis_tlast  = out_res.last;
    assign m_axis_tuser  = out_res.kind;

endmodule

`default_nettype wire

@@ dv/content_length_deframer_tb.sv @@
// Self-checking testbench for content_length_deframer: header parsing, body pass-through
// and every error result, checked against a predictor of the deframer kept in this file.
// Depends on clen_pkg and the deframer RTL only.
`default_nettype none

module content_length_deframer_tb;
    import clen_pkg::*;

    localparam int ITEM_TARGET   = 750;     // stop the random part after this many requests
    localparam int CYCLE_LIMIT   = 400000;  // watchdog, many times the slowest correct run
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off to back up the pipe
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 16;      // margin for stray results after the drain

    localparam logic [8*PREFIX_LEN-1:0] TAG_TEXT = "Content-Length:";

    // Per-line parse state of the header phase.
    typedef enum logic [2:0] {
        L_MATCH,
        L_SKIP,
        L_SIGN,
        L_DIGITS,
        L_DONE,
        L_IGNORE
    } line_mode_t;

    // One row of the directed table. Rows with typed set carry a hand-written
    // error result (out_byte zero, last set, length zero); the rest use the predictor.
    typedef struct {
        logic [7:0] data;
        logic       eoi;
        logic       typed;
        kind_t      kind;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        s_axis_tuser;    // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [7:0] out_byte, [39:8] message_length
    logic        m_axis_tlast;    // last
    logic [2:0]  m_axis_tuser;    // [2:0] kind

    // Predictor state of the deframer.
    logic       in_body;
    line_mode_t line_mode;
    int         tag_pos;
    logic       line_has_text;
    len_t       acc;
    logic       acc_neg;
    logic       len_valid;
    len_t       len_val;
    logic       len_neg;
    len_t       body_left;

    result_t    expected_deframed[$];
    logic [7:0] hdr_bytes[$];

    int   error_count = 0;
    int   items_sent  = 0;
    int   msg_count   = 0;
    int   cycle_count = 0;
    bit   calm        = 1'b0;   // no idling on either side while set
    bit   hold_req    = 1'b0;
    bit   hold_begun  = 1'b0;
    int   hold_left   = 0;

    always #5 clk = ~clk;

    content_length_deframer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] tag_char(input int pos);
        return TAG_TEXT[8*(PREFIX_LEN-1-pos) +: 8];
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] b,
                                            input logic l, input len_t n);
        result_t r;
        r.kind           = k;
        r.out_byte       = b;
        r.last           = l;
        r.message_length = n;
        return r;
    endfunction

    task automatic clear_line();
        line_mode     = L_MATCH;
        tag_pos       = 0;
        line_has_text = 1'b0;
        acc           = '0;
        acc_neg       = 1'b0;
    endtask

    // Back to the header phase with nothing known; also taken after every closing result.
    task automatic reset_parser();
        in_body   = 1'b0;
        clear_line();
        len_valid = 1'b0;
        len_val   = '0;
        len_neg   = 1'b0;
        body_left = '0;
    endtask

    // Advance the predictor by one accepted request; return the result it causes, if any.
    task automatic deframe_step(input logic [7:0] c, input logic eoi,
                                output bit produced, output result_t r);
        logic [63:0] digit;
        logic [63:0] limit;
        produced = 1'b0;
        r        = '0;
        limit    = 64'(LEN_MAX);
        if (!in_body)
        begin
            if (eoi)
            begin
                r        = make_result(KIND_HDR_END, 8'h00, 1'b1, '0);
                produced = 1'b1;
                reset_parser();
            end
            else if (c == CH_CR)
            begin
                // drop CR anywhere in the headers
            end
            else if (c == CH_LF)
            begin
                if (!line_has_text)
                begin
                    // blank line: close the headers
                    if (!len_valid || len_neg)
                    begin
                        r        = make_result(KIND_NO_LEN, 8'h00, 1'b1, '0);
                        produced = 1'b1;
                        reset_parser();
                    end
                    else if (len_val == 0)
                    begin
                        r        = make_result(KIND_EMPTY, 8'h00, 1'b1, '0);
                        produced = 1'b1;
                        reset_parser();
                    end
                    else
                    begin
                        clear_line();
                        in_body   = 1'b1;
                        body_left = len_val;
                    end
                end
                else
                begin
                    // commit a length line; the last one wins
                    if (line_mode inside {L_SKIP, L_SIGN, L_DIGITS, L_DONE})
                    begin
                        len_valid = 1'b1;
                        len_val   = acc;
                        len_neg   = acc_neg && (acc != 0);
                    end
                    clear_line();
                end
            end
            else
            begin
                line_has_text = 1'b1;
                case (line_mode)
                    L_MATCH:
                    begin
                        if (c == tag_char(tag_pos))
                        begin
                            tag_pos++;
                            if (tag_pos >= PREFIX_LEN)
                                line_mode = L_SKIP;
                        end
                        else
                        begin
                            line_mode = L_IGNORE;
                        end
                    end
                    L_SKIP, L_SIGN, L_DIGITS:
                    begin
                        if (line_mode == L_SKIP &&
                            (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF))
                        begin
                            // skip leading whitespace
                        end
                        else if (line_mode == L_SKIP && (c == CH_PLUS || c == CH_MINUS))
                        begin
                            acc_neg   = (c == CH_MINUS);
                            line_mode = L_SIGN;
                        end
                        else if (c >= CH_ZERO && c <= CH_NINE)
                        begin
                            digit = 64'(c - CH_ZERO);
                            if (64'(acc) > (limit - digit) / 10)
                                acc = LEN_MAX;
                            else
                                acc = len_t'(64'(acc) * 10 + digit);
                            line_mode = L_DIGITS;
                        end
                        else
                        begin
                            line_mode = L_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (eoi)
        begin
            r        = make_result(KIND_TRUNC, 8'h00, 1'b1, len_val);
            produced = 1'b1;
            reset_parser();
        end
        else
        begin
            if (body_left > 0)
                body_left--;
            produced = 1'b1;
            if (body_left == 0)
            begin
                r = make_result(KIND_BODY, c, 1'b1, len_val);
                reset_parser();
            end
            else
            begin
                r = make_result(KIND_BODY, c, 1'b0, len_val);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    function automatic bit roll_idle();
        return !calm && ($urandom_range(99) < 10);
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_LF);
        return b;
    endfunction

    // Offer one request; called and returning at a falling edge. Predict on acceptance.
    task automatic send_item(input logic [7:0] data, input logic eoi,
                             input logic typed, input kind_t typed_kind);
        bit      produced;
        result_t predicted;
        while (roll_idle())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= eoi;
        do
            @(posedge clk);
        while (!s_axis_tready);
        deframe_step(data, eoi, produced, predicted);
        if (typed)
        begin
            produced  = 1'b1;
            predicted = make_result(typed_kind, 8'h00, 1'b1, '0);
        end
        if (produced)
            expected_deframed.push_back(predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            hdr_bytes.push_back(s[i]);
    endtask

    // A Content-Length line with random whitespace, sign, digits and trailing text.
    task automatic add_length_line();
        string num;
        int    r;
        for (int i = 0; i < PREFIX_LEN; i++)
            hdr_bytes.push_back(tag_char(i));
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0:       hdr_bytes.push_back(CH_SPACE);
                1:       hdr_bytes.push_back(CH_TAB);
                2:       hdr_bytes.push_back(CH_VT);
                default: hdr_bytes.push_back(CH_FF);
            endcase
        end
        r = $urandom_range(9);
        if (r < 2)
            hdr_bytes.push_back(CH_PLUS);
        else if (r < 4)
            hdr_bytes.push_back(CH_MINUS);
        // keep most lengths small so bodies stay short; huge ones get truncated
        r = $urandom_range(99);
        if (r < 10)
        begin
            num = "";
        end
        else if (r < 16)
        begin
            num = ($urandom_range(1) != 0) ? "0" : "000";
        end
        else if (r < 70)
        begin
            num = $sformatf("%0d", $urandom_range(1, 9));
            if ($urandom_range(4) == 0)
                num = {"0", num};
        end
        else if (r < 80)
        begin
            num = $sformatf("%0d", $urandom_range(10, 40));
        end
        else if (r < 90)
        begin
            case ($urandom_range(0, 4))
                0:       num = "4294967295";
                1:       num = "4294967296";
                2:       num = "4294967294";
                3:       num = "429496730";
                default: num = "18446744073709551616";
            endcase
        end
        else
        begin
            num = "";
            repeat ($urandom_range(10, 14))
                hdr_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        push_text(num);
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3))
                hdr_bytes.push_back(rand_text_byte());
        if ($urandom_range(99) < 30)
            hdr_bytes.push_back(CH_CR);
        hdr_bytes.push_back(CH_LF);
    endtask

    // Any line that is not a header we care about; may hold CR and NUL.
    task automatic add_junk_line();
        logic [7:0] b;
        do
            b = rand_text_byte();
        while (b == CH_CR);
        hdr_bytes.push_back(b);
        repeat ($urandom_range(0, 9))
            hdr_bytes.push_back(rand_text_byte());
        hdr_bytes.push_back(CH_LF);
    endtask

    // Tag cut short or with one letter in the wrong case.
    task automatic add_near_miss_line();
        int p;
        p = $urandom_range(0, PREFIX_LEN - 1);
        for (int i = 0; i < p; i++)
            hdr_bytes.push_back(tag_char(i));
        if ($urandom_range(1) != 0)
            hdr_bytes.push_back(tag_char(p) ^ 8'h20);
        hdr_bytes.push_back(CH_ZERO + 8'd5);
        hdr_bytes.push_back(CH_LF);
    endtask

    task automatic send_body();
        len_t left;
        int   k;
        left = body_left;
        // back up the whole pipe once, while results are flowing
        if (!hold_req && msg_count >= 5 && left >= 4)
            hold_req = 1'b1;
        if (left <= 40 && $urandom_range(99) < 85)
        begin
            repeat (int'(left))
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, KIND_BODY);
        end
        else
        begin
            k = (left > 7) ? $urandom_range(0, 6) : $urandom_range(0, int'(left) - 1);
            repeat (k)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, KIND_BODY);
            send_item(8'($urandom_range(255)), 1'b1, 1'b0, KIND_BODY);
        end
    endtask

    // Well-formed header block, sometimes cut by end of input, then its body.
    task automatic send_message();
        int r;
        int cut;
        hdr_bytes.delete();
        repeat ($urandom_range(1, 4))
        begin
            r = $urandom_range(99);
            if (r < 50)
                add_length_line();
            else if (r < 80)
                add_junk_line();
            else
                add_near_miss_line();
        end
        if ($urandom_range(1) != 0)
            hdr_bytes.push_back(CH_CR);
        hdr_bytes.push_back(CH_LF);
        cut = ($urandom_range(99) < 5) ? $urandom_range(0, hdr_bytes.size() - 1) : -1;
        foreach (hdr_bytes[i])
        begin
            if (i == cut)
            begin
                send_item(8'($urandom_range(255)), 1'b1, 1'b0, KIND_BODY);
                return;
            end
            send_item(hdr_bytes[i], 1'b0, 1'b0, KIND_BODY);
        end
        if (in_body)
            send_body();
    endtask

    // Short bursts of raw bytes, line ends and end marks.
    task automatic send_noise();
        int r;
        repeat ($urandom_range(1, 12))
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_item(8'($urandom_range(255)), 1'b1, 1'b0, KIND_BODY);
            else if (r < 25)
                send_item(CH_LF, 1'b0, 1'b0, KIND_BODY);
            else if (r < 32)
                send_item(CH_CR, 1'b0, 1'b0, KIND_BODY);
            else
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, KIND_BODY);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls plus one long hold-off, counted here
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_req && !hold_begun)
        begin
            hold_begun = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !roll_idle();
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare each accepted result with the oldest expectation, field by field.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_deframed.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                          m_axis_tuser, m_axis_tdata[7:0]));
            end
            else
            begin
                want = expected_deframed.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
                if (m_axis_tdata[7:0] !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_axis_tdata[7:0], want.out_byte));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
                if (m_axis_tdata[39:8] !== want.message_length)
                    report_mismatch($sformatf("message_length %0d, want %0d",
                                              m_axis_tdata[39:8], want.message_length));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        plan_row_t plan[$];
        int        drain;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        reset_parser();

        // Directed requests: end marks at line start and mid-tag, blank lines, CR, odd bytes.
        plan.push_back(plan_row_t'{8'h00, 1'b1, 1'b1, KIND_HDR_END}); // end right after reset
        plan.push_back(plan_row_t'{8'hFF, 1'b1, 1'b1, KIND_HDR_END}); // byte ignored with end
        plan.push_back(plan_row_t'{CH_LF, 1'b0, 1'b1, KIND_NO_LEN});  // blank, no length
        plan.push_back(plan_row_t'{CH_CR, 1'b0, 1'b0, KIND_BODY});    // CR dropped
        plan.push_back(plan_row_t'{CH_LF, 1'b0, 1'b1, KIND_NO_LEN});  // still a blank line
        plan.push_back(plan_row_t'{8'h00, 1'b0, 1'b0, KIND_BODY});    // NUL makes line nonempty
        plan.push_back(plan_row_t'{CH_LF, 1'b0, 1'b0, KIND_BODY});
        plan.push_back(plan_row_t'{CH_LF, 1'b0, 1'b1, KIND_NO_LEN});
        plan.push_back(plan_row_t'{8'hFF, 1'b0, 1'b0, KIND_BODY});    // non-header line
        plan.push_back(plan_row_t'{8'h43, 1'b0, 1'b0, KIND_BODY});
        plan.push_back(plan_row_t'{CH_LF, 1'b0, 1'b0, KIND_BODY});
        plan.push_back(plan_row_t'{8'h43, 1'b0, 1'b0, KIND_BODY});    // partial tag pending
        plan.push_back(plan_row_t'{8'h6F, 1'b0, 1'b0, KIND_BODY});
        plan.push_back(plan_row_t'{8'h6F, 1'b1, 1'b1, KIND_HDR_END}); // end mid-line
        plan.push_back(plan_row_t'{CH_LF, 1'b0, 1'b1, KIND_NO_LEN});
        plan.push_back(plan_row_t'{8'h00, 1'b1, 1'b1, KIND_HDR_END}); // end right after restart

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_item(plan[i].data, plan[i].eoi, plan[i].typed, plan[i].kind);

        // Mostly well-formed messages with random content, some noise; one calm stretch.
        while (items_sent < ITEM_TARGET)
        begin
            msg_count++;
            calm = (msg_count >= 12 && msg_count < 20);
            if ($urandom_range(99) < 12)
                send_noise();
            else
                send_message();
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        drain = 0;
        while (expected_deframed.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_deframed.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_deframed.size()));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/clen_pkg.sv
hw/rtl/clen_in_reg.sv
hw/rtl/clen_core.sv
hw/rtl/clen_out_reg.sv
hw/rtl/content_length_deframer.sv
dv/content_length_deframer_tb.sv
